### sv/page_extent_allocator_unit_macros.svh
// Assertion macros for the page extent allocator.
`ifndef PAGE_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_EXTENT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define PEA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define PEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pea_pkg.sv
// Package: types, codes and defaults of the page extent allocator.
package pea_pkg;

    localparam int FREE_ENTRIES_DEF   = 128;
    localparam int RECORD_ENTRIES_DEF = 1024;
    localparam int PAGE_BITS_DEF      = 12;

    localparam int PAGE_W = 20;
    localparam int LEN_W  = 21;
    localparam int ADDR_W = 32;

    localparam logic [PAGE_W-1:0] REGION_START_RST = 20'd528384;
    localparam logic [LEN_W-1:0]  REGION_PAGES_RST = 21'd321408;

    localparam logic [0:0] CFG_REGION_START = 1'b0;
    localparam logic [0:0] CFG_REGION_PAGES = 1'b1;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_INIT    = 2'd2;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NOFIT    = 3'd1,
        STAT_RECFULL  = 3'd2,
        STAT_UNKNOWN  = 3'd3,
        STAT_FREEFULL = 3'd4
    } status_t;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } extent_t;

endpackage

### sv/page_extent_allocator_unit.sv
// Top level: page-granular first-fit allocator over free-extent and record memories.
`include "page_extent_allocator_unit_macros.svh"

// Page extent allocator. Requests arrive on s_* (tuser = function code,
// tdata = request_bytes then release_address); each request yields one
// response on m_* (tdata = granted address, tuser = status). Both tables live
// in single-port-read synchronous memories and are scanned one entry per cycle:
// an allocate runs a first-fit scan of the free table, then a search for an
// empty record; a release runs an address match in the records, then the
// merge scan of the free table. Initialize sweeps both memories and loads the
// region as free entry zero. After reset the same sweep clears both memories
// while s_tready stays low.
// The response register lets a new request enter while a response waits.
// Write the region registers through cfg_* only while the block is idle.
module page_extent_allocator_unit #(
    parameter int FREE_ENTRIES   = pea_pkg::FREE_ENTRIES_DEF,
    parameter int RECORD_ENTRIES = pea_pkg::RECORD_ENTRIES_DEF,
    parameter int PAGE_BITS      = pea_pkg::PAGE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] request_bytes, [63:32] release_address
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] granted_address
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    import pea_pkg::*;

    localparam int FW    = $clog2(FREE_ENTRIES);
    localparam int RW    = $clog2(RECORD_ENTRIES);
    localparam int CW    = ((FW > RW) ? FW : RW) + 1;
    localparam int SWEEP = (FREE_ENTRIES > RECORD_ENTRIES) ? FREE_ENTRIES : RECORD_ENTRIES;
    localparam int PGW   = 33 - PAGE_BITS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_AFREE = 8'b0000_0100,
        S_AREC  = 8'b0000_1000,
        S_RREC  = 8'b0001_0000,
        S_RFREE = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // Memories
    extent_t free_mem [FREE_ENTRIES];
    extent_t rec_mem  [RECORD_ENTRIES];
    extent_t free_rd_reg, rec_rd_reg;
    logic    free_re, rec_re, free_we, rec_we;
    logic [FW-1:0] free_waddr;
    logic [RW-1:0] rec_waddr;
    extent_t free_wdata, rec_wdata;

    // Control and payload registers
    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next, chk_idx_reg, chk_idx_next;
    logic chk_vld_reg, chk_vld_next;
    logic init_reg, init_next;
    logic [PAGE_W-1:0] region_start_reg;
    logic [LEN_W-1:0]  region_pages_reg;
    logic [PGW-1:0] pages_reg, pages_next;
    logic [31:0] raddr_reg, raddr_next;
    extent_t hit_reg, hit_next;           // matched free extent or record
    logic [FW-1:0] fidx_reg, fidx_next;
    logic [RW-1:0] ridx_reg, ridx_next;
    extent_t fnew_reg, fnew_next, rnew_reg, rnew_next;
    logic [31:0] res_addr_reg, res_addr_next;
    status_t res_stat_reg, res_stat_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] m_addr_reg, m_addr_next;
    status_t m_stat_reg, m_stat_next;

    logic [32:0] bytes_sum;
    logic [PGW-1:0] pages_in;
    logic free_scan, rec_scan, scan_issue, scan_none;
    logic [CW-1:0] depth;
    logic [PAGE_W-1:0] rend, fend;
    logic [LEN_W:0] merged_sum;
    logic [LEN_W-1:0] merged_len;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_addr_reg;
    assign m_tuser   = m_stat_reg;

    // Round bytes up to pages; a zero request takes one page.
    assign bytes_sum = {1'b0, s_tdata[31:0]} + 33'((33'd1 << PAGE_BITS) - 33'd1);
    assign pages_in  = (bytes_sum[32:PAGE_BITS] == '0) ? PGW'(1) : bytes_sum[32:PAGE_BITS];

    assign free_scan  = (state_reg == S_AFREE) || (state_reg == S_RFREE);
    assign rec_scan   = (state_reg == S_AREC) || (state_reg == S_RREC);
    assign depth      = free_scan ? CW'(FREE_ENTRIES) : CW'(RECORD_ENTRIES);
    assign scan_issue = (free_scan || rec_scan) && (idx_reg < depth);
    assign scan_none  = !chk_vld_reg && (idx_reg == depth);
    assign free_re    = free_scan && scan_issue;
    assign rec_re     = rec_scan && scan_issue;

    assign rend       = hit_reg.start + hit_reg.length[PAGE_W-1:0];
    assign fend       = free_rd_reg.start + free_rd_reg.length[PAGE_W-1:0];
    assign merged_sum = {1'b0, free_rd_reg.length} + {1'b0, hit_reg.length};
    assign merged_len = merged_sum[LEN_W] ? {LEN_W{1'b1}} : merged_sum[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_waddr] <= free_wdata;
        end
        if (free_re) begin
            free_rd_reg <= free_mem[idx_reg[FW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re) begin
            rec_rd_reg <= rec_mem[idx_reg[RW-1:0]];
        end
    end

    // Memory write ports: clearing sweep or the final update of an operation.
    always_comb begin
        free_we    = 1'b0;
        rec_we     = 1'b0;
        free_waddr = fidx_reg;
        rec_waddr  = ridx_reg;
        free_wdata = fnew_reg;
        rec_wdata  = rnew_reg;
        if (state_reg == S_CLEAR) begin
            free_we    = (idx_reg < CW'(FREE_ENTRIES));
            rec_we     = (idx_reg < CW'(RECORD_ENTRIES));
            free_waddr = idx_reg[FW-1:0];
            rec_waddr  = idx_reg[RW-1:0];
            free_wdata = '0;
            rec_wdata  = '0;
            if (init_reg && idx_reg == '0) begin
                free_wdata = '{start: region_start_reg, length: region_pages_reg};
            end
        end else if (state_reg == S_WRITE) begin
            free_we = 1'b1;
            rec_we  = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = 1'b0;
        init_next     = init_reg;
        pages_next    = pages_reg;
        raddr_next    = raddr_reg;
        hit_next      = hit_reg;
        fidx_next     = fidx_reg;
        ridx_next     = ridx_reg;
        fnew_next     = fnew_reg;
        rnew_next     = rnew_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_addr_next   = m_addr_reg;
        m_stat_next   = m_stat_reg;

        // Advance the scan pointer; compare the entry read on the previous cycle.
        if (scan_issue) begin
            chk_vld_next = 1'b1;
            chk_idx_next = idx_reg;
            idx_next     = idx_reg + CW'(1);
        end

        unique case (state_reg)
            S_CLEAR: begin
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(SWEEP - 1)) begin
                    idx_next   = '0;
                    state_next = init_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                idx_next      = '0;
                res_addr_next = '0;
                res_stat_next = STAT_OK;
                if (s_tvalid) begin
                    pages_next = pages_in;
                    raddr_next = s_tdata[63:32];
                    priority case (s_tuser)
                        FUNC_ALLOC:   state_next = S_AFREE;
                        FUNC_RELEASE: state_next = S_RREC;
                        FUNC_INIT: begin
                            init_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_AFREE: begin
                if (chk_vld_reg && (33'(free_rd_reg.length) >= 33'(pages_reg))) begin
                    hit_next   = free_rd_reg;
                    fidx_next  = chk_idx_reg[FW-1:0];
                    idx_next   = '0;
                    chk_vld_next = 1'b0;
                    state_next = S_AREC;
                end else if (scan_none) begin
                    res_stat_next = STAT_NOFIT;
                    state_next    = S_DONE;
                end
            end
            S_AREC: begin
                if (chk_vld_reg && rec_rd_reg.length == '0) begin
                    ridx_next     = chk_idx_reg[RW-1:0];
                    rnew_next     = '{start: hit_reg.start, length: LEN_W'(pages_reg)};
                    fnew_next     = '{start: hit_reg.start + PAGE_W'(pages_reg),
                                      length: hit_reg.length - LEN_W'(pages_reg)};
                    res_addr_next = 32'(hit_reg.start) << PAGE_BITS;
                    chk_vld_next  = 1'b0;
                    state_next    = S_WRITE;
                end else if (scan_none) begin
                    res_stat_next = STAT_RECFULL;
                    state_next    = S_DONE;
                end
            end
            S_RREC: begin
                if (chk_vld_reg && rec_rd_reg.length != '0 &&
                    ((32'(rec_rd_reg.start) << PAGE_BITS) == raddr_reg)) begin
                    hit_next     = rec_rd_reg;
                    ridx_next    = chk_idx_reg[RW-1:0];
                    rnew_next    = '0;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    state_next   = S_RFREE;
                end else if (scan_none) begin
                    res_stat_next = STAT_UNKNOWN;
                    state_next    = S_DONE;
                end
            end
            S_RFREE: begin
                if (chk_vld_reg) begin
                    fidx_next = chk_idx_reg[FW-1:0];
                    priority if (free_rd_reg.start == rend) begin
                        fnew_next    = '{start: free_rd_reg.start - hit_reg.length[PAGE_W-1:0],
                                         length: merged_len};
                        chk_vld_next = 1'b0;
                        state_next   = S_WRITE;
                    end else if (fend == hit_reg.start) begin
                        fnew_next    = '{start: free_rd_reg.start, length: merged_len};
                        chk_vld_next = 1'b0;
                        state_next   = S_WRITE;
                    end else if (free_rd_reg.length == '0) begin
                        fnew_next    = hit_reg;
                        chk_vld_next = 1'b0;
                        state_next   = S_WRITE;
                    end else begin
                        fidx_next = fidx_reg;
                    end
                end else if (scan_none) begin
                    res_stat_next = STAT_FREEFULL;
                    state_next    = S_DONE;
                end
            end
            S_WRITE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                init_next = 1'b0;
                idx_next  = '0;
                // Hold until the response register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = (res_stat_reg == STAT_OK) ? res_addr_reg : '0;
                    m_stat_next  = res_stat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            idx_reg          <= '0;
            chk_idx_reg      <= '0;
            chk_vld_reg      <= 1'b0;
            init_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            region_start_reg <= REGION_START_RST;
            region_pages_reg <= REGION_PAGES_RST;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_idx_reg <= chk_idx_next;
            chk_vld_reg <= chk_vld_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_REGION_START: region_start_reg <= cfg_data[PAGE_W-1:0];
                    CFG_REGION_PAGES: region_pages_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pages_reg    <= pages_next;
        raddr_reg    <= raddr_next;
        hit_reg      <= hit_next;
        fidx_reg     <= fidx_next;
        ridx_reg     <= ridx_next;
        fnew_reg     <= fnew_next;
        rnew_reg     <= rnew_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        m_addr_reg   <= m_addr_next;
        m_stat_reg   <= m_stat_next;
    end

    `PEA_ASSERT_NOW(a_err_zero_addr, m_valid_reg && (m_stat_reg != STAT_OK), m_addr_reg == '0, "failed response carries an address")
    `PEA_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `PEA_ASSERT_NOW(a_idx_bound, 1'b1, idx_reg <= CW'(SWEEP), "scan pointer past table depth")

endmodule

### bench/extent_checker.sv
// Checker for the page extent allocator: mirrors its tables and checks each response.
`timescale 1ns / 100ps

module extent_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] request_bytes, [63:32] release_address
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] granted_address
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [20:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);
    import pea_pkg::*;

    localparam int FREE_N = FREE_ENTRIES_DEF;
    localparam int REC_N  = RECORD_ENTRIES_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } answer_t;

    logic [PAGE_W-1:0] region_start;
    logic [LEN_W-1:0]  region_len;
    logic [PAGE_W-1:0] hole_start [FREE_N];
    logic [LEN_W-1:0]  hole_len   [FREE_N];
    logic [PAGE_W-1:0] lease_start [REC_N];
    logic [LEN_W-1:0]  lease_len   [REC_N];
    answer_t           answers_due [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void wipe_tables();
        for (int i = 0; i < FREE_N; i++) begin
            hole_start[i] = '0;
            hole_len[i]   = '0;
        end
        for (int i = 0; i < REC_N; i++) begin
            lease_start[i] = '0;
            lease_len[i]   = '0;
        end
    endfunction

    function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] a,
                                              input logic [LEN_W-1:0] b);
        logic [LEN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    endfunction

    // First fit: carve pages off the front of the first extent large enough.
    function automatic status_t carve_pages(input logic [31:0] bytes,
                                            output logic [ADDR_W-1:0] addr);
        logic [32:0] pages;
        int y;
        int x;
        addr  = '0;
        pages = ({1'b0, bytes} + 33'((1 << PAGE_BITS_DEF) - 1)) >> PAGE_BITS_DEF;
        if (pages == 0) pages = 1;
        for (y = 0; y < FREE_N; y++)
            if (33'(hole_len[y]) >= pages) break;
        if (y == FREE_N) return STAT_NOFIT;
        for (x = 0; x < REC_N; x++)
            if (lease_len[x] == 0) break;
        if (x == REC_N) return STAT_RECFULL;
        lease_start[x] = hole_start[y];
        lease_len[x]   = pages[LEN_W-1:0];
        addr           = ADDR_W'(hole_start[y]) << PAGE_BITS_DEF;
        hole_start[y]  = hole_start[y] + pages[PAGE_W-1:0];
        hole_len[y]    = hole_len[y] - pages[LEN_W-1:0];
        return STAT_OK;
    endfunction

    // Give a block back into the first free entry that abuts it (one merge, below or above) or is empty.
    function automatic status_t return_pages(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0] rs;
        logic [PAGE_W-1:0] rend;
        logic [LEN_W-1:0]  rl;
        int x;
        int y;
        for (x = 0; x < REC_N; x++)
            if (lease_len[x] != 0 && (ADDR_W'(lease_start[x]) << PAGE_BITS_DEF) == addr)
                break;
        if (x == REC_N) return STAT_UNKNOWN;
        rs   = lease_start[x];
        rl   = lease_len[x];
        rend = rs + rl[PAGE_W-1:0];
        for (y = 0; y < FREE_N; y++) begin
            if (hole_start[y] == rend) begin
                hole_start[y] = hole_start[y] - rl[PAGE_W-1:0];
                hole_len[y]   = grow(hole_len[y], rl);
                break;
            end else if (hole_start[y] + hole_len[y][PAGE_W-1:0] == rs) begin
                hole_len[y] = grow(hole_len[y], rl);
                break;
            end else if (hole_len[y] == 0) begin
                hole_start[y] = rs;
                hole_len[y]   = rl;
                break;
            end
        end
        if (y == FREE_N) return STAT_FREEFULL;
        lease_start[x] = '0;
        lease_len[x]   = '0;
        return STAT_OK;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        logic [ADDR_W-1:0] addr;
        if (!aresetn) begin
            region_start = REGION_START_RST;
            region_len   = REGION_PAGES_RST;
            wipe_tables();
            answers_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REGION_START: region_start = cfg_data[PAGE_W-1:0];
                    CFG_REGION_PAGES: region_len   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                addr        = '0;
                want.status = STAT_OK;
                case (s_tuser)
                    FUNC_ALLOC:   want.status = carve_pages(s_tdata[31:0], addr);
                    FUNC_RELEASE: want.status = return_pages(s_tdata[63:32]);
                    FUNC_INIT: begin
                        wipe_tables();
                        hole_start[0] = region_start;
                        hole_len[0]   = region_len;
                    end
                    default: ;
                endcase
                want.addr = (want.status == STAT_OK) ? addr : '0;
                answers_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $error("response with nothing pending: address %h status %0d",
                           m_tdata, m_tuser);
                    mismatches <= mismatches + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata !== want.addr || m_tuser !== want.status) begin
                        if (m_tdata !== want.addr)
                            $error("granted_address: expected %h, got %h", want.addr, m_tdata);
                        if (m_tuser !== want.status)
                            $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        outstanding <= answers_due.size();
    end

endmodule

### bench/testbench.sv
// Testbench top: drives requests and configuration into the allocator and gives the verdict.
`timescale 1ns / 100ps

module testbench;
    import pea_pkg::*;

    // Code the block must answer without touching its tables.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 20000;
    // Longest single operation: a full scan of both tables plus overhead.
    localparam int OP_CYCLES = FREE_ENTRIES_DEF + RECORD_ENTRIES_DEF + 4;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] request_bytes, [63:32] release_address
    logic [1:0]  s_tuser   = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] granted_address
    logic [2:0]  m_tuser;          // [2:0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [20:0] cfg_data  = '0;

    int          mismatches;
    int          outstanding;
    int          sent      = 0;
    int          idle_run  = 0;
    bit          steady    = 1'b0;   // no idling on either side while set
    bit          hold_go   = 1'b0;   // ask the receiver for a long hold-off
    int          hold_left = 0;
    logic [31:0] live [$];           // addresses granted and not yet given back

    initial begin
        forever #10 aclk = ~aclk;
    end

    page_extent_allocator_unit dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    extent_checker scoreboard (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .mismatches, .outstanding
    );

    // Collect granted addresses so later releases can hit live blocks.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tuser == STAT_OK && m_tdata != 0)
            live.push_back(m_tdata);
    end

    // Hang detection: count cycles in which no channel moves anything.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // Offer one request and hold it until accepted; maybe idle first.
    task automatic issue(input logic [1:0] code, input logic [31:0] bytes,
                         input logic [31:0] where);
        if (!steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {where, bytes};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (code == FUNC_INIT) live.delete();
    endtask

    // Drop valid and wait until every response has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [20:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_region(input logic [PAGE_W-1:0] first, input logic [LEN_W-1:0] pages);
        write_reg(CFG_REGION_START, 21'(first));
        write_reg(CFG_REGION_PAGES, pages);
    endtask

    // Byte address of a page in the managed space.
    function automatic logic [31:0] page_addr(input logic [PAGE_W-1:0] pg);
        return 32'(pg) << PAGE_BITS_DEF;
    endfunction

    initial begin
        logic [31:0] target;
        int          pick;
        int          roll;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Default region: sizes at the edges, a merge above, bad codes.
        issue(FUNC_INIT, $urandom, $urandom);
        issue(FUNC_ALLOC, 32'd0, 32'd0);              // zero bytes -> one page
        issue(FUNC_ALLOC, 32'd1, 32'd0);
        issue(FUNC_ALLOC, 32'd4096, 32'd0);
        issue(FUNC_ALLOC, 32'd4097, 32'd0);           // spills into a second page
        issue(FUNC_RELEASE, 32'd0, page_addr(REGION_START_RST));          // new free slot
        issue(FUNC_RELEASE, 32'd0, page_addr(REGION_START_RST + 20'd1));  // merge above
        issue(FUNC_RELEASE, 32'd0, page_addr(REGION_START_RST));          // now unknown
        issue(FUNC_RELEASE, 32'd0, 32'hFFFF_FFFF);
        issue(FUNC_RELEASE, 32'd0, page_addr(REGION_START_RST) + 1);      // off by a byte
        issue(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);      // no extent fits

        // Region that wraps past the top page number; merge below on release.
        set_region(20'hFFFF0, 21'd32);
        issue(FUNC_INIT, 32'd0, 32'd0);
        issue(FUNC_ALLOC, 32'd20 * 32'd4096, 32'd0);
        issue(FUNC_ALLOC, 32'd4096, 32'd0);
        issue(FUNC_RELEASE, 32'd0, page_addr(20'hFFFF0));
        issue(FUNC_RELEASE, 32'd0, page_addr(20'h00004));
        issue(FUNC_ALLOC, 32'd32 * 32'd4096, 32'd0);

        // Empty region, then the largest region at the lowest and highest start.
        set_region(20'd0, 21'd0);
        issue(FUNC_INIT, 32'd0, 32'd0);
        issue(FUNC_ALLOC, 32'd0, 32'd0);
        set_region(20'd0, 21'd1048576);
        issue(FUNC_INIT, 32'd0, 32'd0);
        issue(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
        issue(FUNC_RELEASE, 32'd0, 32'd0);
        set_region(20'hFFFFF, 21'd1048576);
        issue(FUNC_INIT, 32'd0, 32'd0);
        issue(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
        issue(FUNC_RELEASE, 32'd0, page_addr(20'hFFFFF));

        // Punch holes until the free table overflows.
        set_region(REGION_START_RST, REGION_PAGES_RST);
        issue(FUNC_INIT, 32'd0, 32'd0);
        for (int i = 0; i < 2 * FREE_ENTRIES_DEF + 4; i++)
            issue(FUNC_ALLOC, 32'd0, 32'd0);
        for (int i = 0; i < FREE_ENTRIES_DEF + 2; i++)
            issue(FUNC_RELEASE, 32'd0, page_addr(REGION_START_RST + 20'(2 * i)));

        // Random phases: mostly live alloc/release traffic, some noise.
        for (int ph = 0; ph < 5; ph++) begin
            set_region(20'($urandom_range(0, 20'hFFFFF)),
                       (ph == 0) ? REGION_PAGES_RST : 21'($urandom_range(0, 1048576)));
            steady = (ph == 1);
            if (ph == 2) hold_go = 1'b1;
            issue(FUNC_INIT, $urandom, $urandom);
            for (int i = 0; i < 20; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 30 && live.size() != 0) begin
                    pick   = $urandom_range(0, live.size() - 1);
                    target = live[pick];
                    live.delete(pick);
                    issue(FUNC_RELEASE, $urandom, target);
                end else if (roll < 75) begin
                    issue(FUNC_ALLOC, $urandom_range(0, 65535), $urandom);
                end else if (roll < 85) begin
                    issue(FUNC_RELEASE, $urandom, $urandom);
                end else if (roll < 92) begin
                    issue(FUNC_ALLOC, $urandom, $urandom);
                end else if (roll < 96) begin
                    issue(FUNC_UNUSED, $urandom, $urandom);
                end else begin
                    issue(FUNC_INIT, $urandom, $urandom);
                end
            end
        end
        steady = 1'b0;

        // Drain, then give the block time to show any stray response.
        settle();
        repeat (OP_CYCLES + 100) @(posedge aclk);
        $display("Sent %0d requests: edge sizes, wrapped and empty regions,", sent);
        $display("free table overflow, and random mixed traffic with long stalls.");
        if (outstanding != 0)
            $error("%0d responses never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
